// ===== src/rcmp_pkg.sv =====
// Shared types and fixed widths for the rod cutting profit block.
// No dependencies; compile first.
package rcmp_pkg;

  localparam int PRICE_W  = 16;
  localparam int PROFIT_W = 22;
  localparam logic [PROFIT_W-1:0] PROFIT_MAX = {PROFIT_W{1'b1}};

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_RUN,
    ST_DRAIN,
    ST_WRITE,
    ST_OUT
  } rcmp_state_t;

endpackage

// ===== src/rcmp_if.sv =====
// Valid/ready channel interfaces for price beats and result beats.
// Depends on rcmp_pkg.
interface rcmp_price_if;
  import rcmp_pkg::*;
  logic               valid;
  logic               ready;
  logic [PRICE_W-1:0] price;
  logic               last_price;
  modport source (output valid, price, last_price, input ready);
  modport sink   (input valid, price, last_price, output ready);
endinterface

interface rcmp_result_if;
  import rcmp_pkg::*;
  logic                valid;
  logic                ready;
  logic [PROFIT_W-1:0] max_profit;
  logic                too_long;
  modport source (output valid, max_profit, too_long, input ready);
  modport sink   (input valid, max_profit, too_long, output ready);
endinterface

// ===== src/rcmp_ram.sv =====
// Generic single write port RAM with one registered read port.
// No dependencies.
module rcmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/rod_cutting_max_profit.sv =====
// Rod cutting maximum profit: top level with sequencer and add-compare unit.
// Depends on rcmp_pkg, rcmp_if.sv and rcmp_ram.
//
// Price beats are taken one per cycle while loading; the first beat is the
// price of length 1, the next of length 2, and so on, up to MAX_LEN stored
// prices (later ones are dropped and too_long is set). The beat marked
// last_price starts the computation and the input is not ready until the
// result beat is taken. One shared adder and comparator walks the profit
// table bottom-up through the two RAM read ports, one candidate per cycle
// while running; each length then passes a drain and a write state. The
// result is held in an output register until taken.
module rod_cutting_max_profit #(
  parameter int MAX_LEN = 64
) (
  input logic           clk,
  input logic           rst,
  rcmp_price_if.sink    prices,
  rcmp_result_if.source result
);
  import rcmp_pkg::*;

  localparam int CW  = $clog2(MAX_LEN + 1);
  localparam int PAW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int QAW = $clog2(MAX_LEN + 1);

  rcmp_state_t state, state_next;

  logic [CW-1:0]       count;
  logic                overflow;
  logic [CW-1:0]       idx_i;
  logic [CW-1:0]       idx_j;
  logic                acc_vld;
  logic                acc_zero;
  logic [PROFIT_W:0]   best;
  logic [PROFIT_W-1:0] best_sat;
  logic [PROFIT_W:0]   cand;
  logic [PROFIT_W-1:0] max_profit;
  logic                too_long;

  logic                accept;
  logic                store_ok;
  logic [CW-1:0]       j_dec;
  logic [CW-1:0]       i_minus_j;

  logic [PRICE_W-1:0]  price_rd;
  logic [PROFIT_W-1:0] profit_rd;
  logic                profit_we;

  assign accept    = prices.valid && prices.ready;
  assign store_ok  = count < CW'(MAX_LEN);
  assign j_dec     = idx_j - CW'(1);
  assign i_minus_j = idx_i - idx_j;
  assign profit_we = (state == ST_WRITE);

  // Price store, written during loading, read at j - 1
  rcmp_ram #(.WIDTH(PRICE_W), .DEPTH(MAX_LEN)) u_price_ram (
    .clk   (clk),
    .we    (accept && store_ok),
    .waddr (count[PAW-1:0]),
    .wdata (prices.price),
    .raddr (j_dec[PAW-1:0]),
    .rdata (price_rd)
  );

  // Profit table, entries 1..MAX_LEN; entry zero is forced to zero
  rcmp_ram #(.WIDTH(PROFIT_W), .DEPTH(MAX_LEN + 1)) u_profit_ram (
    .clk   (clk),
    .we    (profit_we),
    .waddr (idx_i[QAW-1:0]),
    .wdata (best_sat),
    .raddr (i_minus_j[QAW-1:0]),
    .rdata (profit_rd)
  );

  // Shared add-compare datapath
  assign cand = {{(PROFIT_W + 1 - PRICE_W){1'b0}}, price_rd} +
                {1'b0, (acc_zero ? {PROFIT_W{1'b0}} : profit_rd)};
  assign best_sat = (best > {1'b0, PROFIT_MAX}) ? PROFIT_MAX : best[PROFIT_W-1:0];

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (accept && prices.last_price) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (idx_j == idx_i) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_WRITE;
      ST_WRITE: begin
        state_next = (idx_i == count) ? ST_OUT : ST_RUN;
      end
      ST_OUT: begin
        if (result.ready) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Load count and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      overflow <= 1'b0;
    end else if (accept) begin
      if (store_ok) begin
        count <= count + CW'(1);
      end else begin
        overflow <= 1'b1;
      end
    end else if (state == ST_OUT && result.ready) begin
      count    <= '0;
      overflow <= 1'b0;
    end
  end

  // Loop counters and read pipeline flag
  always_ff @(posedge clk) begin
    if (rst) begin
      acc_vld <= 1'b0;
      idx_i   <= CW'(1);
      idx_j   <= CW'(1);
    end else begin
      acc_vld <= (state == ST_RUN);
      unique case (state)
        ST_LOAD: begin
          idx_i <= CW'(1);
          idx_j <= CW'(1);
        end
        ST_RUN: begin
          if (idx_j != idx_i) idx_j <= idx_j + CW'(1);
        end
        ST_WRITE: begin
          idx_i <= idx_i + CW'(1);
          idx_j <= CW'(1);
        end
        default: ;
      endcase
    end
  end

  // Running best and result register
  always_ff @(posedge clk) begin
    acc_zero <= (i_minus_j == '0);
    if (state == ST_WRITE) begin
      best <= '0;
      if (idx_i == count) begin
        max_profit <= best_sat;
        too_long   <= overflow;
      end
    end else if (state == ST_LOAD) begin
      best <= '0;
    end else if (acc_vld && cand > best) begin
      best <= cand;
    end
  end

  assign prices.ready      = (state == ST_LOAD);
  assign result.valid      = (state == ST_OUT);
  assign result.max_profit = max_profit;
  assign result.too_long   = too_long;

endmodule
